// ===== sv/cdrf_pkg.sv =====
// Package for the chunk difference region finder: word types, register map and defaults.
`timescale 1ns / 1ps

package cdrf_pkg;

	localparam int OFFSET_WIDTH_DEF = 32;
	localparam int CHUNK_WIDTH_DEF  = 16;

	localparam int ADDR_WIDTH = 4;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_CHUNK_SIZE       = 2'd0;
	localparam logic [1:0] REG_REPORT_UNCHANGED = 2'd1;
	localparam logic [1:0] REG_BASE_OFFSET      = 2'd2;

	localparam logic [15:0] CHUNK_SIZE_RST = 16'd8;

	typedef struct packed {
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [31:0] region_offset;
		logic [31:0] region_length;
		logic        region_valid;
		logic        scan_done;
		logic        overflow;
	} out_word_t;

endpackage

// ===== sv/chunk_diff_region_finder.sv =====
// Top level of the chunk difference region finder.
//
//  Channel  | Direction | Handshake                         | Word
//  ---------+-----------+-----------------------------------+-----------------------------
//  in       | input     | in_valid / in_ready               | in_word_t (byte pair, last)
//  out      | output    | out_valid / out_ready             | out_word_t (region result)
//  config   | input     | psel, penable, pwrite, pready = 1 | 32-bit registers at 0, 4, 8
//
// One byte pair is accepted per cycle while out does not stall; each word is held in the
// input register, resolved there against the scan state, and its result, if any, is
// written into the output register when the word advances. The state update of position,
// chunk and run counters sets that rate. A stall on out only holds the pipe while a result
// is waiting in the output register. Reset clears the scan state and loads the register defaults.
`timescale 1ns / 1ps

module chunk_diff_region_finder
	import cdrf_pkg::*;
#(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
	parameter int CHUNK_WIDTH  = CHUNK_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,

	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int OW = OFFSET_WIDTH;
	localparam int CW = CHUNK_WIDTH;
	localparam int LW = ((OW > CW + 1) ? OW : CW + 1) + 1;
	localparam int AW = (OW > 32) ? OW : 32;

	// Configuration registers.
	logic [15:0] chunk_size_q;
	logic        report_unchanged_q;
	logic [31:0] base_offset_q;

	// Scan state.
	logic [OW-1:0] position_q;
	logic [CW-1:0] chunk_fill_q;
	logic          chunk_mismatch_q;
	logic          run_open_q;
	logic [OW-1:0] run_start_q;
	logic [OW-1:0] run_length_q;
	logic          overflowed_q;

	// Input stage and output register.
	logic      v_s1;
	in_word_t  in_s1;
	logic      out_valid_q;
	out_word_t out_data_q;

	logic adv;
	logic cfg_wr;

	// Step logic.
	logic [CW-1:0] size_w;
	logic          mism;
	logic          pos_max;
	logic [OW-1:0] pos_next;
	logic          ovf_next;
	logic [CW:0]   fill_now;
	logic          chunk_end;
	logic          qual;
	logic [LW-1:0] rl_sum;
	logic [OW-1:0] rl_sat;
	logic          open_after;
	logic [OW-1:0] start_after;
	logic [OW-1:0] len_after;
	logic          emit;
	logic          res_valid;
	logic [AW-1:0] off_sum;
	logic [OW-1:0] off_w;
	out_word_t     res_word;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	assign adv      = v_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~v_s1 | adv;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_CHUNK_SIZE:       prdata = 32'(chunk_size_q);
			REG_REPORT_UNCHANGED: prdata = 32'(report_unchanged_q);
			REG_BASE_OFFSET:      prdata = base_offset_q;
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q       <= CHUNK_SIZE_RST;
			report_unchanged_q <= 1'b0;
			base_offset_q      <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CHUNK_SIZE:       chunk_size_q       <= pwdata[15:0];
				REG_REPORT_UNCHANGED: report_unchanged_q <= pwdata[0];
				REG_BASE_OFFSET:      base_offset_q      <= pwdata;
				default:              ;
			endcase
		end
	end

	always_comb begin
		size_w = CW'(chunk_size_q);
		if (size_w == '0) begin
			size_w = CW'(1);
		end
		mism      = chunk_mismatch_q | (in_s1.byte_a != in_s1.byte_b);
		pos_max   = &position_q;
		pos_next  = pos_max ? position_q : position_q + OW'(1);
		ovf_next  = overflowed_q | pos_max;
		fill_now  = {1'b0, chunk_fill_q} + (CW+1)'(1);
		chunk_end = in_s1.last_byte | (fill_now >= {1'b0, size_w});
		// A chunk qualifies when its mismatch flag differs from the report-unchanged flag.
		qual      = mism ^ report_unchanged_q;

		rl_sum = LW'(run_length_q) + LW'(fill_now);
		rl_sat = (|rl_sum[LW-1:OW]) ? '1 : rl_sum[OW-1:0];

		open_after  = run_open_q;
		start_after = run_start_q;
		len_after   = run_length_q;
		if (qual) begin
			open_after = 1'b1;
			if (run_open_q) begin
				len_after = rl_sat;
			end else begin
				start_after = position_q - OW'(chunk_fill_q);
				len_after   = OW'(fill_now);
			end
		end
		emit      = chunk_end & ~qual & run_open_q;
		res_valid = chunk_end & (in_s1.last_byte | emit);

		off_sum = AW'(base_offset_q) + AW'(start_after);
		off_w   = off_sum[OW-1:0];

		res_word.region_valid  = open_after;
		res_word.region_offset = open_after ? 32'(off_w) : '0;
		res_word.region_length = open_after ? 32'(len_after) : '0;
		res_word.scan_done     = in_s1.last_byte;
		res_word.overflow      = ovf_next;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
		if (adv) begin
			out_data_q <= res_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1             <= 1'b0;
			out_valid_q      <= 1'b0;
			position_q       <= '0;
			chunk_fill_q     <= '0;
			chunk_mismatch_q <= 1'b0;
			run_open_q       <= 1'b0;
			run_start_q      <= '0;
			run_length_q     <= '0;
			overflowed_q     <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end

			if (adv) begin
				out_valid_q <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (adv) begin
				position_q   <= pos_next;
				overflowed_q <= ovf_next;
				if (!chunk_end) begin
					chunk_fill_q     <= fill_now[CW-1:0];
					chunk_mismatch_q <= mism;
				end else begin
					chunk_fill_q     <= '0;
					chunk_mismatch_q <= 1'b0;
					if (in_s1.last_byte) begin
						// The scan ends here and the next word starts a fresh one.
						position_q   <= '0;
						overflowed_q <= 1'b0;
						run_open_q   <= 1'b0;
						run_start_q  <= '0;
						run_length_q <= '0;
					end else if (emit) begin
						run_open_q   <= 1'b0;
						run_start_q  <= '0;
						run_length_q <= '0;
					end else begin
						run_open_q   <= open_after;
						run_start_q  <= start_after;
						run_length_q <= len_after;
					end
				end
			end
		end
	end

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.region_valid |->
			out_data.region_offset == '0 && out_data.region_length == '0)
		else $error("result without a region carries a nonzero offset or length");

	a_mid_scan_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.scan_done |-> out_data.region_valid)
		else $error("result before the end of the scan does not describe a region");

	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_s1.last_byte |=>
			position_q == '0 && !run_open_q && !overflowed_q && chunk_fill_q == '0)
		else $error("scan state not cleared after the last byte");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid_q && !out_ready)
		else $error("input stalled while the pipe can move");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the chunk difference region finder.
`timescale 1ns / 1ps

module tb;
	import cdrf_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 70;

	// Index 3 decodes to no register; writes there must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [31:0] reg_val;
		in_word_t    word;
		logic        fixed;
		out_word_t   want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	chunk_diff_region_finder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Register shadows and scan state of the predictor.
	logic [15:0] cfg_chunk_size = CHUNK_SIZE_RST;
	logic        cfg_report_unchanged = 1'b0;
	logic [31:0] cfg_base_offset = '0;

	logic [31:0] scan_pos = '0;
	logic [15:0] chunk_fill = '0;
	logic        chunk_diff = 1'b0;
	logic        run_open = 1'b0;
	logic [31:0] run_start = '0;
	logic [31:0] run_length = '0;
	logic        pos_saturated = 1'b0;

	out_word_t pending_regions[$];
	stim_row_t dir_rows[$];
	int        error_count = 0;
	bit        hold_results = 1'b0;

	function automatic void add_row(input stim_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic void note_region(input out_word_t r);
		pending_regions.insert(pending_regions.size(), r);
	endfunction

	// Works out the region result, if any, that one byte pair closes.
	task automatic track_byte(input in_word_t w, output bit hit, output out_word_t res);
		logic [16:0] size;
		logic [16:0] fill_now;
		logic [31:0] cur;
		logic [32:0] sum;
		bit          qual;
		bit          emit;
		size = (cfg_chunk_size == '0) ? 17'd1 : {1'b0, cfg_chunk_size};
		cur = scan_pos;
		hit = 1'b0;
		emit = 1'b0;
		res = '0;
		if (w.byte_a != w.byte_b)
			chunk_diff = 1'b1;
		if (scan_pos == '1)
			pos_saturated = 1'b1;
		else
			scan_pos = scan_pos + 32'd1;
		fill_now = {1'b0, chunk_fill} + 17'd1;
		if (!w.last_byte && fill_now < size) begin
			chunk_fill = fill_now[15:0];
		end else begin
			qual = chunk_diff ? !cfg_report_unchanged : cfg_report_unchanged;
			if (qual) begin
				if (run_open) begin
					sum = {1'b0, run_length} + {16'd0, fill_now};
					run_length = sum[32] ? '1 : sum[31:0];
				end else begin
					run_open = 1'b1;
					run_start = cur - {16'd0, chunk_fill};
					run_length = {15'd0, fill_now};
				end
			end else if (run_open) begin
				emit = 1'b1;
			end
			chunk_fill = '0;
			chunk_diff = 1'b0;
			if (w.last_byte || emit) begin
				hit = 1'b1;
				res.region_valid = run_open;
				res.region_offset = run_open ? cfg_base_offset + run_start : '0;
				res.region_length = run_open ? run_length : '0;
				res.scan_done = w.last_byte;
				res.overflow = pos_saturated;
				run_open = 1'b0;
				run_start = '0;
				run_length = '0;
				if (w.last_byte) begin
					scan_pos = '0;
					pos_saturated = 1'b0;
				end
			end
		end
	endtask

	function automatic stim_row_t byte_row(input logic [7:0] a, input logic [7:0] b,
			input logic last);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.word = {a, b, last};
		return r;
	endfunction

	function automatic stim_row_t fixed_row(input logic [7:0] a, input logic [7:0] b,
			input logic last, input out_word_t want);
		stim_row_t r;
		r = byte_row(a, b, last);
		r.fixed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 25);
	endfunction

	// Offers one word, and records its expected result at the accepting edge.
	task automatic push_word(input in_word_t w, input bit fixed, input out_word_t want,
			input int gap);
		bit        hit;
		out_word_t res;
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_byte(w, hit, res);
		if (fixed)
			note_region(want);
		else if (hit)
			note_region(res);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// A word that closes no region may still be inside the block when the queue empties.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_regions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		paddr <= {idx, 2'b00};
		pwdata <= val;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CHUNK_SIZE:       cfg_chunk_size = val[15:0];
			REG_REPORT_UNCHANGED: cfg_report_unchanged = val[0];
			REG_BASE_OFFSET:      cfg_base_offset = val;
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_regions.size() == 0) begin
				$error("region result with nothing expected: %0h", out_data);
				error_count++;
			end else begin
				want = pending_regions.pop_front();
				check_field("region_offset", want.region_offset, out_data.region_offset);
				check_field("region_length", want.region_length, out_data.region_length);
				check_field("region_valid", 32'(want.region_valid),
						32'(out_data.region_valid));
				check_field("scan_done", 32'(want.scan_done), 32'(out_data.scan_done));
				check_field("overflow", 32'(want.overflow), 32'(out_data.overflow));
			end
		end
	end

	// Result side: random stalls, long ready stretches, and one long hold-off on request.
	initial begin
		int high_len;
		int low_len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
			high_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(10, 40);
			out_ready <= 1'b1;
			repeat (high_len) @(posedge clk);
			low_len = $urandom_range(0, 9);
			if (low_len >= 5)
				low_len = (low_len == 9) ? $urandom_range(8, 20) : $urandom_range(1, 3);
			else
				low_len = 0;
			if (low_len > 0) begin
				out_ready <= 1'b0;
				repeat (low_len) @(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		stim_row_t row;
		in_word_t  w;
		logic [7:0] flip;
		int  eff;
		int  gen_fill;
		int  diff_at;
		int  scan_left;
		bit  gen_diff;
		bit  noise;
		bit  burst;

		// Reset values: chunks of eight, changed regions, no base offset.
		add_row(fixed_row(8'h00, 8'h00, 1'b1, {32'h0, 32'd0, 1'b0, 1'b1, 1'b0}));
		add_row(fixed_row(8'hFF, 8'h00, 1'b1, {32'h0, 32'd1, 1'b1, 1'b1, 1'b0}));
		add_row(fixed_row(8'hFF, 8'hFF, 1'b1, {32'h0, 32'd0, 1'b0, 1'b1, 1'b0}));
		add_row(fixed_row(8'h00, 8'hFF, 1'b1, {32'h0, 32'd1, 1'b1, 1'b1, 1'b0}));
		// One differing chunk, then a short clean chunk that ends the scan.
		add_row(byte_row(8'h80, 8'h01, 1'b0));
		add_row(byte_row(8'h11, 8'h11, 1'b0));
		add_row(byte_row(8'h22, 8'h22, 1'b0));
		add_row(byte_row(8'h44, 8'h44, 1'b0));
		add_row(byte_row(8'h88, 8'h88, 1'b0));
		add_row(byte_row(8'h55, 8'h55, 1'b0));
		add_row(byte_row(8'hAA, 8'hAA, 1'b0));
		add_row(byte_row(8'h7E, 8'h7E, 1'b0));
		add_row(byte_row(8'h01, 8'h01, 1'b0));
		add_row(byte_row(8'h02, 8'h02, 1'b0));
		add_row(fixed_row(8'h03, 8'h03, 1'b1, {32'h0, 32'd8, 1'b1, 1'b1, 1'b0}));
		// Chunk size zero acts as one; matching regions; the base offset wraps.
		add_row(reg_row(REG_CHUNK_SIZE, 32'd0));
		add_row(reg_row(REG_REPORT_UNCHANGED, 32'd1));
		add_row(reg_row(REG_BASE_OFFSET, 32'hFFFF_FFFF));
		add_row(reg_row(REG_UNUSED, 32'd5));
		add_row(byte_row(8'h12, 8'h12, 1'b0));
		add_row(byte_row(8'h34, 8'h34, 1'b0));
		add_row(fixed_row(8'h56, 8'h65, 1'b0, {32'hFFFF_FFFF, 32'd2, 1'b1, 1'b0, 1'b0}));
		add_row(fixed_row(8'h7F, 8'h7F, 1'b1, {32'h2, 32'd1, 1'b1, 1'b1, 1'b0}));
		// The chunk size drops below the fill of an open chunk.
		add_row(reg_row(REG_REPORT_UNCHANGED, 32'd0));
		add_row(reg_row(REG_CHUNK_SIZE, 32'd8));
		add_row(reg_row(REG_BASE_OFFSET, 32'h100));
		add_row(byte_row(8'h01, 8'h02, 1'b0));
		add_row(byte_row(8'h03, 8'h03, 1'b0));
		add_row(byte_row(8'h03, 8'h03, 1'b0));
		add_row(reg_row(REG_CHUNK_SIZE, 32'd2));
		add_row(byte_row(8'h04, 8'h04, 1'b0));
		add_row(byte_row(8'h00, 8'h00, 1'b1));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_REG) begin
				wait_idle();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				push_word(row.word, row.fixed, row.want, pick_gap(1'b0));
			end
		end

		gen_diff = 1'b0;
		scan_left = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph % 6)
				0: write_reg(REG_CHUNK_SIZE, 32'd1);
				1: write_reg(REG_CHUNK_SIZE, 32'd65535);
				2: write_reg(REG_CHUNK_SIZE, 32'd3);
				3: write_reg(REG_CHUNK_SIZE, 32'd0);
				4: write_reg(REG_CHUNK_SIZE, $urandom_range(2, 12));
				default: write_reg(REG_CHUNK_SIZE,
						(ph < 6) ? $urandom_range(13, 60) : $urandom_range(61, 65534));
			endcase
			write_reg(REG_REPORT_UNCHANGED, (ph >= 6) ? 32'd1 : 32'd0);
			case (ph % 3)
				0: write_reg(REG_BASE_OFFSET, 32'd0);
				1: write_reg(REG_BASE_OFFSET, 32'hFFFF_FFFF);
				default: write_reg(REG_BASE_OFFSET, $urandom);
			endcase
			burst = (ph % 4 == 1);
			// With the sender running flat out, this hold-off backs the block up.
			if (ph == 5)
				hold_results = 1'b1;
			eff = (cfg_chunk_size == 0) ? 1 : int'(cfg_chunk_size);
			gen_fill = 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (scan_left == 0) begin
					if ($urandom_range(0, 7) == 0)
						scan_left = 1;
					else if (eff <= 12)
						scan_left = $urandom_range(1, 6 * eff);
					else
						scan_left = $urandom_range(1, 40);
				end
				if (gen_fill == 0) begin
					if ($urandom_range(0, 2) == 0)
						gen_diff = !gen_diff;
					diff_at = $urandom_range(0, ((eff < scan_left) ? eff : scan_left) - 1);
				end
				w.byte_a = 8'($urandom_range(0, 255));
				flip = 8'($urandom_range(1, 255));
				noise = ($urandom_range(0, 9) == 0);
				if (noise)
					w.byte_b = 8'($urandom_range(0, 255));
				else if (gen_diff && (gen_fill == diff_at || $urandom_range(0, 7) == 0))
					w.byte_b = w.byte_a ^ flip;
				else
					w.byte_b = w.byte_a;
				w.last_byte = (scan_left == 1) || (noise && $urandom_range(0, 4) == 0);
				scan_left--;
				gen_fill++;
				if (gen_fill >= eff || w.last_byte)
					gen_fill = 0;
				if (w.last_byte)
					scan_left = 0;
				push_word(w, 1'b0, '0, pick_gap(burst));
			end
		end

		wait_idle();
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
